@@ rtl/core/sfwc_pkg.sv @@
// ---------------------------------------------------------------------------
// sfwc_pkg: shared constants and types
// Result kinds, command codes, nack codes and register indexes.
// ---------------------------------------------------------------------------
package sfwc_pkg;

  localparam int unsigned TrackSlotsDef = 32;

  localparam logic [1:0] CmdStart = 2'd0;
  localparam logic [1:0] CmdData  = 2'd1;
  localparam logic [1:0] CmdNack  = 2'd2;
  localparam logic [1:0] CmdTmo   = 2'd3;

  localparam logic [1:0] NackDelay = 2'd1;
  localparam logic [1:0] NackNoData = 2'd2;

  localparam logic [2:0] KSend    = 3'd0;
  localparam logic [2:0] KRetx    = 3'd1;
  localparam logic [2:0] KFast    = 3'd2;
  localparam logic [2:0] KDelay   = 3'd3;
  localparam logic [2:0] KDeliver = 3'd4;
  localparam logic [2:0] KDone    = 3'd5;
  localparam logic [2:0] KAbort   = 3'd6;
  localparam logic [2:0] KSpan    = 3'd7;

  localparam logic [2:0] RegMinWin = 3'd0;
  localparam logic [2:0] RegMaxWin = 3'd1;
  localparam logic [2:0] RegMaxRetx = 3'd2;
  localparam logic [2:0] RegFastThr = 3'd3;
  localparam logic [2:0] RegMaxExcl = 3'd4;

  localparam int unsigned MaxResults = 64;

  // one result beat
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seg;
    logic [15:0] delay;
  } res_t;

endpackage

@@ rtl/core/sfwc_res_fifo.sv @@
// ---------------------------------------------------------------------------
// sfwc_res_fifo: result queue
// Holds the result beats of one event; last is flagged on the final entry.
// ---------------------------------------------------------------------------
module sfwc_res_fifo import sfwc_pkg::*; #(
  parameter int unsigned Depth = MaxResults
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  res_t   push_data_i,
  input  logic   close_i,       // event done: last entry pushed so far is final
  output logic   empty_o,
  output logic   pop_valid_o,
  output res_t   pop_data_o,
  output logic   pop_last_o,
  input  logic   pop_i
);
  localparam int unsigned AW = $clog2(Depth);

  res_t mem_q [Depth];
  logic [AW:0] wr_q, rd_q, end_q;
  logic closed_q;
  logic full;
  logic load;
  res_t out_data_q;
  logic out_valid_q, out_last_q;

  assign full = (wr_q - rd_q) == (AW + 1)'(Depth);
  // next entry moves into the output register when it is free or popped
  assign load = closed_q && (rd_q != end_q) && (!out_valid_q || pop_i);
  assign empty_o = (wr_q == rd_q) && !closed_q && !out_valid_q;

  always_ff @(posedge clk_i) begin
    if (push_i && !full) mem_q[wr_q[AW-1:0]] <= push_data_i;
    if (load) out_data_q <= mem_q[rd_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      end_q <= '0;
      closed_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      if (push_i && !full) wr_q <= wr_q + 1'b1;
      if (close_i) begin
        // an event without results closes straight away
        closed_q <= (wr_q != rd_q);
        end_q <= wr_q;
      end
      if (load) begin
        rd_q <= rd_q + 1'b1;
        out_valid_q <= 1'b1;
        out_last_q <= (rd_q + 1'b1) == end_q;
        if (rd_q + 1'b1 == end_q) closed_q <= 1'b0;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entries are only shown once the event is closed, so last is known
  assign pop_valid_o = out_valid_q;
  assign pop_data_o  = out_data_q;
  assign pop_last_o  = out_last_q;
endmodule

@@ rtl/core/segment_fetch_window_controller.sv @@
// ---------------------------------------------------------------------------
// segment_fetch_window_controller: receiver-side AIMD fetch window
// Sequencer over the tracking slots, one slot step per cycle.
// ---------------------------------------------------------------------------
// Flow: the gap scan counts received slots behind each open gap, one slot
//   per cycle; the delivery and send loops take one slot each; beats are held
//   until the event closes and then drain one beat per cycle while out_ready_i
//   is high.
// Throughput: one event at a time; in_ready_o returns once all beats left.
// Reset: async active low; registers take their reset values, marks clear.
module segment_fetch_window_controller import sfwc_pkg::*; #(
  parameter int unsigned TRACK_SLOTS = TrackSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] segment_i,
  input  logic        verified_i,
  input  logic        has_final_i,
  input  logic [31:0] final_segment_i,
  input  logic [1:0]  nack_code_i,
  input  logic [15:0] nack_delay_ms_i,
  input  logic [3:0]  exclude_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [31:0] out_segment_o,
  output logic [15:0] delay_ms_o,
  output logic [5:0]  window_now_o,
  output logic        last_o
);
  localparam int unsigned SW = $clog2(TRACK_SLOTS);
  localparam int unsigned CW = SW + 1;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_GAP   = 4'd2;  // pick next unreceived slot
  localparam logic [3:0] S_CNT   = 4'd3;  // count received after it
  localparam logic [3:0] S_POSTG = 4'd4;
  localparam logic [3:0] S_DLV   = 4'd5;
  localparam logic [3:0] S_SEND  = 4'd6;
  localparam logic [3:0] S_TDLV  = 4'd7;
  localparam logic [3:0] S_CLOSE = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;

  logic [3:0] st_q, st_d;

  // configuration
  logic [5:0] min_win_q, max_win_q;
  logic [7:0] max_retx_q;
  logic [3:0] fast_thr_q, max_excl_q;

  // session state
  logic        running_q, final_known_q;
  logic [5:0]  win_q, flight_q;
  logic [31:0] next_q, final_q, dptr_q, high_q;
  logic [TRACK_SLOTS-1:0] rcv_q, buf_q, frx_q;
  logic [7:0]  retx_q [TRACK_SLOTS];

  // latched event
  logic [1:0]  cmd_q, code_q;
  logic [31:0] seg_q, fin_q;
  logic        ver_q, hasfin_q;
  logic [15:0] delay_q;
  logic [3:0]  excl_q;

  // scan walker
  logic [SW-1:0] gi_q, gj_q;
  logic [CW-1:0] gcnt_q;
  logic [SW-1:0] ghi_q;

  // result push
  logic push;
  res_t push_data;
  logic close;
  logic q_empty, pop_valid, pop_last;
  res_t pop_data;
  logic [6:0] nres_q;

  sfwc_res_fifo #(.Depth(MaxResults)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .close_i(close),
    .empty_o(q_empty), .pop_valid_o(pop_valid), .pop_data_o(pop_data),
    .pop_last_o(pop_last), .pop_i(out_ready_i)
  );

  assign in_ready_o    = (st_q == S_IDLE) && q_empty;
  assign out_valid_o   = pop_valid;
  assign kind_o        = pop_data.kind;
  assign out_segment_o = pop_data.seg;
  assign delay_ms_o    = pop_data.delay;
  assign window_now_o  = win_q;
  assign last_o        = pop_last;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  logic [SW-1:0] sidx;
  assign sidx = seg_q[SW-1:0];
  logic seg_beyond;
  assign seg_beyond = final_known_q && (seg_q > final_q);

  function automatic logic [5:0] f_up(input logic [5:0] v);
    f_up = (v < 6'd63) ? v + 6'd1 : v;
  endfunction

  function automatic logic [5:0] f_shrink(input logic [5:0] w, input logic [5:0] mn);
    logic [5:0] h;
    h = {1'b0, w[5:1]};
    if (w > mn) f_shrink = (h == 6'd0) ? 6'd1 : h;
    else f_shrink = w;
  endfunction

  function automatic logic segment_valid(input logic [31:0] s);
    segment_valid = s < TRACK_SLOTS;
  endfunction

  logic send_go;
  assign send_go = running_q && (flight_q < win_q) && (next_q < TRACK_SLOTS)
                   && !(final_known_q && next_q > final_q);

  logic dlv_go;
  assign dlv_go = (dptr_q < TRACK_SLOTS) && buf_q[dptr_q[SW-1:0]];

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      min_win_q <= 6'd1; max_win_q <= 6'd32; max_retx_q <= 8'd3;
      fast_thr_q <= 4'd3; max_excl_q <= 4'd1;
      running_q <= 1'b0; final_known_q <= 1'b0;
      win_q <= '0; flight_q <= '0;
      next_q <= '0; final_q <= '1; dptr_q <= '0; high_q <= '0;
      rcv_q <= '0; buf_q <= '0; frx_q <= '0;
      for (int k = 0; k < TRACK_SLOTS; k++) retx_q[k] <= '0;
      gi_q <= '0; gj_q <= '0; gcnt_q <= '0; ghi_q <= '0;
      nres_q <= '0;
      cmd_q <= '0; code_q <= '0; seg_q <= '0; fin_q <= '0;
      ver_q <= 1'b0; hasfin_q <= 1'b0; delay_q <= '0; excl_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMinWin:  min_win_q  <= cfg_data_i[5:0];
          RegMaxWin:  max_win_q  <= cfg_data_i[5:0];
          RegMaxRetx: max_retx_q <= cfg_data_i;
          RegFastThr: fast_thr_q <= cfg_data_i[3:0];
          RegMaxExcl: max_excl_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (push && nres_q < 7'(MaxResults)) nres_q <= nres_q + 7'd1;
      st_q <= st_d;
      case (st_q)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= command_i; seg_q <= segment_i; ver_q <= verified_i;
            hasfin_q <= has_final_i; fin_q <= final_segment_i;
            code_q <= nack_code_i; delay_q <= nack_delay_ms_i;
            excl_q <= exclude_count_i; nres_q <= '0;
          end
        end
        S_DEC: begin
          if (cmd_q == CmdStart) begin
            final_known_q <= 1'b0; final_q <= '1; next_q <= 32'd1;
            flight_q <= 6'd1; dptr_q <= '0; high_q <= '0;
            rcv_q <= '0; buf_q <= '0; frx_q <= '0;
            for (int k = 0; k < TRACK_SLOTS; k++) retx_q[k] <= '0;
            running_q <= 1'b1;
          end else if (running_q && segment_valid(seg_q)) begin
            logic [5:0] fl;
            fl = (flight_q > 6'd0) ? flight_q - 6'd1 : flight_q;
            if (cmd_q == CmdData) begin
              if (ver_q) begin
                rcv_q[sidx] <= 1'b1; frx_q[sidx] <= 1'b0;
                if (seg_q > high_q) begin
                  high_q <= seg_q; ghi_q <= sidx;
                end else ghi_q <= (high_q >= TRACK_SLOTS) ? SW'(TRACK_SLOTS-1) : high_q[SW-1:0];
                gi_q <= '0;
                if (win_q < max_win_q) win_q <= win_q + 6'd1;
                if (hasfin_q) begin
                  final_known_q <= 1'b1; final_q <= fin_q;
                end
                buf_q[sidx] <= 1'b1;
              end else if (retx_q[sidx] < max_retx_q && excl_q < max_excl_q) begin
                fl = f_up(fl); retx_q[sidx] <= retx_q[sidx] + 8'd1;
              end else running_q <= 1'b0;
            end else if (cmd_q == CmdNack) begin
              if (!seg_beyond) begin
                if (ver_q) begin
                  rcv_q[sidx] <= 1'b1; frx_q[sidx] <= 1'b0;
                  if (seg_q > high_q) begin
                    high_q <= seg_q; ghi_q <= sidx;
                  end else ghi_q <= (high_q >= TRACK_SLOTS) ? SW'(TRACK_SLOTS-1) : high_q[SW-1:0];
                  gi_q <= '0;
                  win_q <= f_shrink(win_q, min_win_q);
                end else if (retx_q[sidx] < max_retx_q && excl_q < max_excl_q) begin
                  fl = f_up(fl); retx_q[sidx] <= retx_q[sidx] + 8'd1;
                end else running_q <= 1'b0;
              end
            end else begin
              if (!seg_beyond) begin
                win_q <= f_shrink(win_q, min_win_q);
                if (retx_q[sidx] < max_retx_q) begin
                  fl = f_up(fl); retx_q[sidx] <= retx_q[sidx] + 8'd1;
                end else running_q <= 1'b0;
              end
            end
            flight_q <= fl;
          end
        end
        S_GAP: begin
          if (!(rcv_q[gi_q] || frx_q[gi_q]) && gi_q != ghi_q) begin
            gj_q <= gi_q + SW'(1); gcnt_q <= '0;
          end else gi_q <= gi_q + SW'(1);
        end
        S_CNT: begin
          logic [CW-1:0] c;
          c = gcnt_q + CW'(rcv_q[gj_q]);
          gcnt_q <= c;
          if (gj_q == ghi_q) begin
            if (fast_thr_q != 4'd0 && c >= CW'(fast_thr_q)) begin
              frx_q[gi_q] <= 1'b1;
              if (retx_q[gi_q] < max_retx_q) begin
                flight_q <= f_up(flight_q);
                retx_q[gi_q] <= retx_q[gi_q] + 8'd1;
              end
            end
            gi_q <= gi_q + SW'(1);
          end else gj_q <= gj_q + SW'(1);
        end
        S_POSTG: begin
          // nack verified: code-specific follow-up
          if (code_q == NackNoData) running_q <= 1'b0;
          else if (code_q == NackDelay) begin
            if (retx_q[sidx] < max_retx_q) begin
              flight_q <= f_up(flight_q); retx_q[sidx] <= retx_q[sidx] + 8'd1;
            end else running_q <= 1'b0;
          end
        end
        S_DLV, S_TDLV: begin
          if (dptr_q < TRACK_SLOTS && buf_q[dptr_q[SW-1:0]]) begin
            buf_q[dptr_q[SW-1:0]] <= 1'b0;
            dptr_q <= dptr_q + 32'd1;
            if (st_q == S_DLV && final_known_q && dptr_q == final_q) running_q <= 1'b0;
          end
          if (st_d == S_SEND && seg_q == 32'd0)
            win_q <= (final_q < {26'd0, max_win_q}) ? final_q[5:0] : max_win_q;
        end
        S_DRAIN: begin
          // segment zero answered and completed: window still resized
          if (seg_q == 32'd0)
            win_q <= (final_q < {26'd0, max_win_q}) ? final_q[5:0] : max_win_q;
        end
        S_SEND: begin
          if (send_go) begin
            flight_q <= f_up(flight_q);
            retx_q[next_q[SW-1:0]] <= '0;
            next_q <= next_q + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // next state and result push
  always_comb begin
    st_d = st_q;
    push = 1'b0;
    push_data = '{kind: KSend, seg: '0, delay: '0};
    close = 1'b0;
    case (st_q)
      S_IDLE: if (accept) st_d = S_DEC;
      S_DEC: begin
        st_d = S_CLOSE;
        if (cmd_q == CmdStart) begin
          push = 1'b1;
        end else if (!running_q) begin
          st_d = S_CLOSE;
        end else if (!segment_valid(seg_q)) begin
          push = 1'b1; push_data = '{kind: KSpan, seg: seg_q, delay: '0};
        end else if (cmd_q == CmdData) begin
          if (ver_q) st_d = S_GAP;
          else begin
            push = 1'b1;
            push_data.seg = seg_q;
            push_data.kind = (retx_q[sidx] < max_retx_q && excl_q < max_excl_q) ? KRetx : KAbort;
            st_d = S_DLV;
          end
        end else if (cmd_q == CmdNack) begin
          if (seg_beyond) st_d = S_DLV;
          else if (ver_q) st_d = S_GAP;
          else begin
            push = 1'b1;
            push_data.seg = seg_q;
            push_data.kind = (retx_q[sidx] < max_retx_q && excl_q < max_excl_q) ? KRetx : KAbort;
            st_d = S_DLV;
          end
        end else begin
          if (!seg_beyond) begin
            if (retx_q[sidx] < max_retx_q) begin
              push = 1'b1; push_data = '{kind: KRetx, seg: seg_q, delay: '0};
            end else st_d = S_TDLV;
          end
        end
      end
      S_GAP: begin
        if (!(rcv_q[gi_q] || frx_q[gi_q]) && gi_q != ghi_q) st_d = S_CNT;
        else if (gi_q == ghi_q) st_d = (cmd_q == CmdNack) ? S_POSTG : S_DLV;
      end
      S_CNT: begin
        if (gj_q == ghi_q) begin
          if (fast_thr_q != 4'd0 && (gcnt_q + CW'(rcv_q[gj_q])) >= CW'(fast_thr_q)
              && retx_q[gi_q] < max_retx_q) begin
            push = 1'b1; push_data = '{kind: KFast, seg: 32'(gi_q), delay: '0};
          end
          st_d = S_GAP;
        end
      end
      S_POSTG: begin
        st_d = S_DLV;
        if (code_q == NackNoData) begin
          push = 1'b1; push_data = '{kind: KAbort, seg: seg_q, delay: '0};
        end else if (code_q == NackDelay) begin
          push = 1'b1;
          push_data = (retx_q[sidx] < max_retx_q) ? '{kind: KDelay, seg: seg_q, delay: delay_q}
                                                  : '{kind: KAbort, seg: seg_q, delay: '0};
        end
      end
      S_DLV: begin
        // delivery only follows verified data; other paths fall through
        if (cmd_q == CmdData && ver_q && dlv_go) begin
          push = 1'b1; push_data = '{kind: KDeliver, seg: dptr_q, delay: '0};
          if (final_known_q && dptr_q == final_q) st_d = S_IDLE;
        end else st_d = S_SEND;
        if (cmd_q == CmdData && ver_q && dlv_go && final_known_q && dptr_q == final_q)
          st_d = S_DRAIN;
      end
      S_DRAIN: begin
        push = 1'b1; push_data = '{kind: KDone, seg: dptr_q - 32'd1, delay: '0};
        st_d = S_SEND;
      end
      S_TDLV: begin
        if (dlv_go) begin
          push = 1'b1; push_data = '{kind: KDeliver, seg: dptr_q, delay: '0};
        end else begin
          push = 1'b1; push_data = '{kind: KAbort, seg: seg_q, delay: '0};
          st_d = S_CLOSE;
        end
      end
      S_SEND: begin
        if (send_go) begin
          push = 1'b1; push_data = '{kind: KSend, seg: next_q, delay: '0};
        end else st_d = S_CLOSE;
      end
      S_CLOSE: begin
        close = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    if (nres_q >= 7'(MaxResults)) push = 1'b0;
  end

  // no new event while results are pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accepting while results pending");
  a_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SEND && send_go) |=> flight_q != 6'd0) else $error("flight count lost");
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> st_q == S_IDLE) else $error("close outside sequence");
endmodule
